// ===== rtl/cltok_pkg.sv =====
// Shared definitions for the command line tokenizer.
// Character codes, default limits and the result item type.
// No dependencies.
package cltok_pkg;

  // Default limits, overridable through top-level parameters
  localparam int SLASH_MAX_DEF = 255;
  localparam int COUNT_MAX_DEF = 65535;

  // Argument count saturates at the width of its port
  localparam logic [15:0] ARGS_CAP = 16'hFFFF;

  // Character codes that steer the tokenizer
  localparam logic [15:0] CH_EOL    = 16'h0000;
  localparam logic [15:0] CH_TAB    = 16'h0009;
  localparam logic [15:0] CH_SPACE  = 16'h0020;
  localparam logic [15:0] CH_QUOTE  = 16'h0022;
  localparam logic [15:0] CH_BSLASH = 16'h005C;

  // One result item as seen on the output ports
  typedef struct packed {
    logic [7:0]  slash_run;
    logic        has_char;
    logic [15:0] char_out;
    logic        arg_end;
    logic [15:0] arg_count;
    logic [15:0] char_count;
    logic        last_of_run;
  } out_item_t;

endpackage

// ===== rtl/command_line_tokenizer_core.sv =====
// Top level of the command line tokenizer: input register, decode, result queue.
// Depends on cltok_pkg, cltok_step and cltok_outq.
//
//   channel | handshake               | payload
//   --------+-------------------------+--------------------------------------
//   input   | in_valid / in_stall     | char_code
//   output  | out_valid / out_stall   | slash_run has_char char_out arg_end
//           |                         | arg_count char_count last_of_run
//
// One character a cycle when each yields at most one result and the output does
// not stall; a character that yields two results fills the two-entry result queue,
// and the next character waits until the last queued result is being handed out.
// A character passes the input register, then the decode writes the result queue.
// Synchronous reset restores the tokenizer state and empties both registers. An
// output stall backs up through the result queue into in_stall; nothing is dropped.
module command_line_tokenizer_core #(
  parameter int SLASH_MAX = cltok_pkg::SLASH_MAX_DEF,
  parameter int COUNT_MAX = cltok_pkg::COUNT_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  slash_run,
  output logic        has_char,
  output logic [15:0] char_out,
  output logic        arg_end,
  output logic [15:0] arg_count,
  output logic [15:0] char_count,
  output logic        last_of_run
);
  import cltok_pkg::*;

  logic        in_full;
  logic [15:0] in_char;
  logic        room, fire;
  out_item_t   res0, res1, head;
  logic [1:0]  res_cnt;

  // Input register
  assign fire     = in_full && room;
  assign in_stall = in_full && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_char <= char_code;
  end

  // Decode and tokenizer state
  cltok_step #(
    .SLASH_MAX (SLASH_MAX),
    .COUNT_MAX (COUNT_MAX)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .chr     (in_char),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  // Result queue
  cltok_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (fire ? res_cnt : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign slash_run   = head.slash_run;
  assign has_char    = head.has_char;
  assign char_out    = head.char_out;
  assign arg_end     = head.arg_end;
  assign arg_count   = head.arg_count;
  assign char_count  = head.char_count;
  assign last_of_run = head.last_of_run;

endmodule

// ===== rtl/cltok_step.sv =====
// Tokenizer state and per-character decode for the command line tokenizer.
// Produces up to two result items per character; state advances on fire.
// Depends on cltok_pkg.
module cltok_step #(
  parameter int SLASH_MAX = 255,
  parameter int COUNT_MAX = 65535
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [15:0]           chr,
  output cltok_pkg::out_item_t  res0,
  output cltok_pkg::out_item_t  res1,
  output logic [1:0]            res_cnt
);
  import cltok_pkg::*;

  localparam int SW   = $clog2(SLASH_MAX + 1);
  localparam int CW   = $clog2(COUNT_MAX + 1);
  localparam int SUMW = ((CW > SW + 1) ? CW : SW + 1) + 1;

  typedef enum logic [1:0] {PH_NAME, PH_GAP, PH_ARG} phase_t;

  // State registers
  phase_t          phase, phase_next;
  logic            quoting, quoting_next;
  logic [SW-1:0]   pend, pend_next;
  logic            qpend, qpend_next;
  logic [SW-1:0]   held, held_next;
  logic [15:0]     args, args_next;
  logic [CW-1:0]   chars, chars_next;

  // Decode results: A is the early emission, B the one from argument handling
  logic            a_v, a_has, a_end;
  logic [SW-1:0]   a_sl;
  logic            b_v, b_has, b_end;
  logic [SW-1:0]   b_sl;
  logic            done, run_arg, blank;
  logic [SW-1:0]   s;
  // argument count as reported: includes this character's new argument
  logic [15:0]     args_rep;

  logic [SUMW-1:0] sum_a, sum_b;
  logic [CW-1:0]   cnt_a, cnt_b;
  logic [SW+7:0]   a_sl_ext, b_sl_ext;
  logic [CW+15:0]  cnt_a_ext, cnt_b_ext;
  out_item_t       item_a, item_b;

  assign blank = (chr == CH_SPACE) || (chr == CH_TAB);

  // Per-character decode and next state
  always_comb begin
    phase_next   = phase;
    quoting_next = quoting;
    pend_next    = pend;
    qpend_next   = qpend;
    held_next    = held;
    args_next    = args;
    done         = 1'b0;
    run_arg      = 1'b0;
    s            = '0;
    a_v = 1'b0; a_sl = '0; a_has = 1'b0; a_end = 1'b0;
    b_v = 1'b0; b_sl = '0; b_has = 1'b0; b_end = 1'b0;

    unique case (phase)
      PH_GAP: begin
        if (chr == CH_EOL) begin
          done = 1'b1;
        end else if (!blank) begin
          if (args != ARGS_CAP) args_next = args + 16'd1;
          phase_next   = PH_ARG;
          quoting_next = 1'b0;
          pend_next    = '0;
          run_arg      = 1'b1;
        end
      end
      PH_ARG: begin
        if (qpend) begin
          // a held quote is decided by this character
          qpend_next = 1'b0;
          held_next  = '0;
          if (chr == CH_QUOTE) begin
            a_v   = 1'b1;
            a_sl  = held;
            a_has = 1'b1;
          end else begin
            quoting_next = 1'b0;
            a_v          = (held != '0);
            a_sl         = held;
            run_arg      = 1'b1;
          end
        end else begin
          run_arg = 1'b1;
        end
      end
      default: begin
        // program name: quotes toggle, backslashes literal
        if (chr == CH_QUOTE) begin
          quoting_next = !quoting;
        end else if (chr == CH_EOL) begin
          a_v   = 1'b1;
          a_end = 1'b1;
          done  = 1'b1;
        end else if (!quoting && blank) begin
          a_v          = 1'b1;
          a_end        = 1'b1;
          phase_next   = PH_GAP;
          quoting_next = 1'b0;
        end else begin
          a_v   = 1'b1;
          a_has = 1'b1;
        end
      end
    endcase

    // Argument character handling
    if (run_arg) begin
      if (chr == CH_BSLASH) begin
        if (pend_next < SW'(SLASH_MAX)) pend_next = pend_next + SW'(1);
      end else begin
        s         = pend_next;
        pend_next = '0;
        if (chr == CH_QUOTE) begin
          if (!s[0]) begin
            if (quoting_next) begin
              qpend_next = 1'b1;
              held_next  = s >> 1;
            end else begin
              quoting_next = 1'b1;
              b_v          = ((s >> 1) != '0);
              b_sl         = s >> 1;
            end
          end else begin
            b_v   = 1'b1;
            b_sl  = s >> 1;
            b_has = 1'b1;
          end
        end else if (chr == CH_EOL) begin
          b_v   = 1'b1;
          b_sl  = s;
          b_end = 1'b1;
          done  = 1'b1;
        end else if (!quoting_next && blank) begin
          b_v        = 1'b1;
          b_sl       = s;
          b_end      = 1'b1;
          phase_next = PH_GAP;
        end else begin
          b_v   = 1'b1;
          b_sl  = s;
          b_has = 1'b1;
        end
      end
    end

    args_rep = args_next;

    // End of line returns everything to reset values
    if (done) begin
      phase_next   = PH_NAME;
      quoting_next = 1'b0;
      pend_next    = '0;
      qpend_next   = 1'b0;
      held_next    = '0;
      args_next    = 16'd1;
    end
  end

  // Saturating running character count, one adder per emission
  always_comb begin
    sum_a = SUMW'(chars) + SUMW'(a_sl) + SUMW'(a_has | a_end);
    if (!a_v) cnt_a = chars;
    else if (sum_a > SUMW'(COUNT_MAX)) cnt_a = CW'(COUNT_MAX);
    else cnt_a = sum_a[CW-1:0];

    sum_b = SUMW'(cnt_a) + SUMW'(b_sl) + SUMW'(b_has | b_end);
    if (!b_v) cnt_b = cnt_a;
    else if (sum_b > SUMW'(COUNT_MAX)) cnt_b = CW'(COUNT_MAX);
    else cnt_b = sum_b[CW-1:0];

    chars_next = done ? '0 : cnt_b;
  end

  // Result item assembly
  always_comb begin
    a_sl_ext  = {8'b0, a_sl};
    b_sl_ext  = {8'b0, b_sl};
    cnt_a_ext = {16'b0, cnt_a};
    cnt_b_ext = {16'b0, cnt_b};

    item_a.slash_run   = a_sl_ext[7:0];
    item_a.has_char    = a_has;
    item_a.char_out    = a_has ? chr : 16'h0000;
    item_a.arg_end     = a_end;
    item_a.arg_count   = args_rep;
    item_a.char_count  = cnt_a_ext[15:0];
    item_a.last_of_run = !b_v;

    item_b.slash_run   = b_sl_ext[7:0];
    item_b.has_char    = b_has;
    item_b.char_out    = b_has ? chr : 16'h0000;
    item_b.arg_end     = b_end;
    item_b.arg_count   = args_rep;
    item_b.char_count  = cnt_b_ext[15:0];
    item_b.last_of_run = 1'b1;
  end

  assign res0    = a_v ? item_a : item_b;
  assign res1    = item_b;
  assign res_cnt = {a_v & b_v, a_v ^ b_v};

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_NAME;
      quoting <= 1'b0;
      pend    <= '0;
      qpend   <= 1'b0;
      held    <= '0;
      args    <= 16'd1;
      chars   <= '0;
    end else if (fire) begin
      phase   <= phase_next;
      quoting <= quoting_next;
      pend    <= pend_next;
      qpend   <= qpend_next;
      held    <= held_next;
      args    <= args_next;
      chars   <= chars_next;
    end
  end

endmodule

// ===== rtl/cltok_outq.sv =====
// Two-entry result queue for the command line tokenizer.
// Takes up to two items per cycle, hands out one per transfer.
// Depends on cltok_pkg.
module cltok_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_cnt,
  input  cltok_pkg::out_item_t  push0,
  input  cltok_pkg::out_item_t  push1,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cltok_pkg::out_item_t  head
);
  import cltok_pkg::*;

  logic [1:0] cnt, cnt_next, cnt_mid;
  out_item_t  slot0, slot1, slot0_next, slot1_next, slot0_mid;
  logic       pop;

  assign pop       = (cnt != 2'd0) && !out_stall;
  assign out_valid = (cnt != 2'd0);
  assign head      = slot0;
  // a push is allowed only when both slots are free after this cycle's transfer
  assign room      = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  // Pop first, then append new items behind what remains
  always_comb begin
    cnt_mid    = cnt - {1'b0, pop};
    slot0_mid  = pop ? slot1 : slot0;
    slot0_next = slot0_mid;
    slot1_next = slot1;
    cnt_next   = cnt_mid + push_cnt;
    if (push_cnt != 2'd0) begin
      if (cnt_mid == 2'd0) begin
        slot0_next = push0;
        slot1_next = push1;
      end else begin
        slot1_next = push0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

endmodule

// ===== test/cltok_check.sv =====
`timescale 1ns / 1ps
// Transfer monitor and result checker for the command line tokenizer.
// Predicts the result stream of every accepted character and compares it field by field.
// Depends on cltok_pkg.
module cltok_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] char_code,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  slash_run,
  input  logic        has_char,
  input  logic [15:0] char_out,
  input  logic        arg_end,
  input  logic [15:0] arg_count,
  input  logic [15:0] char_count,
  input  logic        last_of_run,
  output int          fail_count,
  output int          results_pending
);
  import cltok_pkg::*;

  typedef enum logic [1:0] {
    TOK_NAME,
    TOK_GAP,
    TOK_ARG
  } tok_phase_t;

  // Tokenizer state as tracked by the predictor
  tok_phase_t phase;
  logic       quoting;
  int         pending_slashes;
  logic       quote_pending;
  int         held_slashes;
  int         args_seen;
  int         chars_seen;
  logic       line_done;
  int         step_results;

  out_item_t  token_results_q[$];

  function automatic logic is_blank(input logic [15:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  task automatic clear_state();
    phase           = TOK_NAME;
    quoting         = 1'b0;
    pending_slashes = 0;
    quote_pending   = 1'b0;
    held_slashes    = 0;
    args_seen       = 1;
    chars_seen      = 0;
  endtask

  // Queue one expected result and advance the saturating character count
  task automatic push_result(input int slashes, input logic has, input logic [15:0] ch,
                             input logic fin);
    out_item_t r;
    int        add;
    add = slashes + ((has || fin) ? 1 : 0);
    chars_seen = (chars_seen + add > COUNT_MAX_DEF) ? COUNT_MAX_DEF : chars_seen + add;
    r.slash_run   = 8'(slashes);
    r.has_char    = has;
    r.char_out    = has ? ch : 16'h0000;
    r.arg_end     = fin;
    r.arg_count   = 16'(args_seen);
    r.char_count  = 16'(chars_seen);
    r.last_of_run = 1'b0;
    token_results_q.push_back(r);
    step_results++;
  endtask

  // One character inside an argument after the program name
  task automatic arg_char(input logic [15:0] c);
    int s;
    if (c == CH_BSLASH) begin
      if (pending_slashes < SLASH_MAX_DEF) pending_slashes++;
      return;
    end
    s = pending_slashes;
    pending_slashes = 0;
    if (c == CH_QUOTE) begin
      if (s % 2 == 0) begin
        if (quoting) begin
          // inside quoting the quote waits for the next character
          quote_pending = 1'b1;
          held_slashes  = s / 2;
        end else begin
          quoting = 1'b1;
          if (s / 2 != 0) push_result(s / 2, 1'b0, 16'h0000, 1'b0);
        end
      end else begin
        push_result(s / 2, 1'b1, c, 1'b0);
      end
    end else if (c == CH_EOL) begin
      push_result(s, 1'b0, 16'h0000, 1'b1);
      line_done = 1'b1;
    end else if (!quoting && is_blank(c)) begin
      push_result(s, 1'b0, 16'h0000, 1'b1);
      phase = TOK_GAP;
    end else begin
      push_result(s, 1'b1, c, 1'b0);
    end
  endtask

  // Expected results of one accepted character
  task automatic predict_char(input logic [15:0] c);
    int        h;
    out_item_t r;
    step_results = 0;
    line_done    = 1'b0;
    case (phase)
      TOK_GAP: begin
        if (c == CH_EOL) begin
          line_done = 1'b1;
        end else if (!is_blank(c)) begin
          if (args_seen < int'(ARGS_CAP)) args_seen++;
          phase           = TOK_ARG;
          quoting         = 1'b0;
          pending_slashes = 0;
          arg_char(c);
        end
      end
      TOK_ARG: begin
        if (quote_pending) begin
          h             = held_slashes;
          quote_pending = 1'b0;
          held_slashes  = 0;
          if (c == CH_QUOTE) begin
            push_result(h, 1'b1, c, 1'b0);
          end else begin
            quoting = 1'b0;
            if (h != 0) push_result(h, 1'b0, 16'h0000, 1'b0);
            arg_char(c);
          end
        end else begin
          arg_char(c);
        end
      end
      default: begin
        // program name: quotes toggle, backslashes are literal
        if (c == CH_QUOTE) begin
          quoting = !quoting;
        end else if (c == CH_EOL) begin
          push_result(0, 1'b0, 16'h0000, 1'b1);
          line_done = 1'b1;
        end else if (!quoting && is_blank(c)) begin
          push_result(0, 1'b0, 16'h0000, 1'b1);
          phase   = TOK_GAP;
          quoting = 1'b0;
        end else begin
          push_result(0, 1'b1, c, 1'b0);
        end
      end
    endcase
    if (step_results > 0) begin
      r = token_results_q.pop_back();
      r.last_of_run = 1'b1;
      token_results_q.push_back(r);
    end
    if (line_done) clear_state();
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare the oldest expectation with an output transfer
  task automatic check_result();
    out_item_t want;
    if (token_results_q.size() == 0) begin
      $error("result transfer with nothing expected: char_out %h", char_out);
      fail_count++;
      return;
    end
    want = token_results_q.pop_front();
    check_field("slash_run", 16'(want.slash_run), 16'(slash_run));
    check_field("has_char", 16'(want.has_char), 16'(has_char));
    check_field("char_out", want.char_out, char_out);
    check_field("arg_end", 16'(want.arg_end), 16'(arg_end));
    check_field("arg_count", want.arg_count, arg_count);
    check_field("char_count", want.char_count, char_count);
    check_field("last_of_run", 16'(want.last_of_run), 16'(last_of_run));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      token_results_q.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_char(char_code);
    end
    results_pending = token_results_q.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the command line tokenizer testbench: clock, reset, character stimulus and verdict.
// Depends on cltok_pkg, command_line_tokenizer_core and cltok_check.
module testbench;
  import cltok_pkg::*;

  localparam int RANDOM_ITEMS = 1300;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [15:0] char_code = 16'h0000;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  slash_run;
  logic        has_char;
  logic [15:0] char_out;
  logic        arg_end;
  logic [15:0] arg_count;
  logic [15:0] char_count;
  logic        last_of_run;

  int          fails;
  int          pending;
  int          chars_sent = 0;
  bit          steady     = 1'b0;
  logic [15:0] line_q[$];

  always #6 clk = ~clk;

  command_line_tokenizer_core dut (
    .clk, .rst, .in_valid, .in_stall, .char_code, .out_valid, .out_stall,
    .slash_run, .has_char, .char_out, .arg_end, .arg_count, .char_count, .last_of_run
  );

  cltok_check u_check (
    .clk, .rst, .in_valid, .in_stall, .char_code, .out_valid, .out_stall,
    .slash_run, .has_char, .char_out, .arg_end, .arg_count, .char_count, .last_of_run,
    .fail_count(fails), .results_pending(pending)
  );

  // Receiver backpressure, off during steady stretches
  always @(posedge clk) out_stall <= !steady && ($urandom_range(99) < 25);

  // Called at a rising edge; returns at the edge of the transfer with valid still high
  task automatic send_char(input logic [15:0] c);
    bit taken;
    while (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
    line_q.delete();
  endtask

  // Hold the sender off until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [15:0] plain_char();
    logic [15:0] c;
    if ($urandom_range(3) == 0) begin
      do c = 16'($urandom_range(65535));
      while (c == CH_EOL || c == CH_TAB || c == CH_SPACE || c == CH_QUOTE || c == CH_BSLASH);
    end else begin
      c = 16'h0061 + 16'($urandom_range(25));
    end
    return c;
  endfunction

  function automatic logic [15:0] noise_char();
    case ($urandom_range(9))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_SPACE;
      3:       return CH_TAB;
      4:       return ($urandom_range(3) == 0) ? CH_EOL : 16'($urandom_range(65535));
      default: return plain_char();
    endcase
  endfunction

  function automatic logic [15:0] blank_char();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  task automatic add_slashes(input int n);
    repeat (n) line_q.push_back(CH_BSLASH);
  endtask

  // Program name: literal backslashes, blanks only in a name that opens with a quote
  task automatic add_name();
    bit quoted;
    quoted = 1'($urandom_range(1));
    if (quoted) line_q.push_back(CH_QUOTE);
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(5))
        0:       line_q.push_back(CH_BSLASH);
        1:       line_q.push_back(quoted ? blank_char() : plain_char());
        2:       if ($urandom_range(3) == 0) line_q.push_back(CH_QUOTE);
        default: line_q.push_back(plain_char());
      endcase
    end
    if (quoted && $urandom_range(4) != 0) line_q.push_back(CH_QUOTE);
  endtask

  // One argument built from backslash runs, quoted segments and doubled quotes
  task automatic add_arg();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(6))
        0: line_q.push_back(plain_char());
        1: begin
          add_slashes($urandom_range(1, 6));
          line_q.push_back(CH_QUOTE);
        end
        2: begin
          add_slashes($urandom_range(1, 6));
          line_q.push_back(plain_char());
        end
        3: begin
          line_q.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(4))
              0: line_q.push_back(blank_char());
              1: begin
                line_q.push_back(CH_QUOTE);
                line_q.push_back(CH_QUOTE);
              end
              2: begin
                add_slashes($urandom_range(1, 4));
                line_q.push_back(CH_QUOTE);
              end
              default: line_q.push_back(plain_char());
            endcase
          end
          line_q.push_back(CH_QUOTE);
        end
        4: line_q.push_back(CH_QUOTE);
        5: begin
          line_q.push_back(CH_QUOTE);
          line_q.push_back(CH_QUOTE);
        end
        default: add_slashes($urandom_range(1, 5));
      endcase
    end
  endtask

  // Mostly well-formed lines; some end without a terminator, some are noise
  task automatic build_line();
    int kind;
    kind = $urandom_range(9);
    if (kind >= 8) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(noise_char());
      return;
    end
    add_name();
    if (kind != 6) begin
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(1, 3)) line_q.push_back(blank_char());
        add_arg();
      end
    end
    if ($urandom_range(3) == 0) line_q.push_back(blank_char());
    if (kind != 7) line_q.push_back(CH_EOL);
  endtask

  initial begin
    int  rand_start;
    bit  paused;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: name quoting, doubled quotes, held runs, extreme codes, empty lines
    line_q = '{CH_QUOTE, 16'h0061, CH_SPACE, 16'h0062, CH_QUOTE, CH_BSLASH, CH_TAB, CH_SPACE,
               CH_BSLASH, CH_BSLASH, CH_QUOTE, 16'h0078, CH_QUOTE, CH_QUOTE, CH_QUOTE, 16'h0079,
               CH_BSLASH, CH_QUOTE, CH_SPACE,
               CH_QUOTE, CH_BSLASH, CH_BSLASH, CH_QUOTE, CH_SPACE,
               16'hFFFF, 16'h8000, 16'h0001, CH_BSLASH, CH_EOL,
               CH_EOL, CH_SPACE, CH_EOL};
    send_line();

    // Backslash runs past saturation, before a quote and before a plain character
    line_q.push_back(16'h0070);
    line_q.push_back(CH_SPACE);
    add_slashes(300);
    line_q.push_back(CH_QUOTE);
    line_q.push_back(CH_SPACE);
    add_slashes(258);
    line_q.push_back(16'h007A);
    line_q.push_back(CH_EOL);
    send_line();
    wait_drained();

    // Random lines, with one steady stretch and one full drain midway
    rand_start = chars_sent;
    paused     = 1'b0;
    while (chars_sent - rand_start < RANDOM_ITEMS) begin
      steady = (chars_sent - rand_start >= 150) && (chars_sent - rand_start < 450);
      if (!paused && chars_sent - rand_start >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      build_line();
      send_line();
    end
    steady = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #48_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
